@@ hw/rtl/tuple_health_circuit_breaker_defines.svh @@
// Assertion macros shared by the checker of the tuple health circuit breaker.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef TUPLE_HEALTH_CIRCUIT_BREAKER_DEFINES_SVH
`define TUPLE_HEALTH_CIRCUIT_BREAKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define THCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define THCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/thcb_pkg.sv @@
// Package for the tuple health circuit breaker: sizes, command codes,
// register indexes and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package thcb_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int OP_W    = 4;
  localparam int FMT_W   = 8;
  localparam int FAIL_W  = 16;
  localparam int SKIP_W  = 17;
  localparam int RETRY_W = 16;
  localparam int THR_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEMOTE_THRESH  = 1'd1;

  localparam logic [RETRY_W-1:0] RETRY_RESET  = 16'd30;
  localparam logic [THR_W-1:0]   THRESH_RESET = 8'd3;

  localparam logic [FAIL_W-1:0]  FAIL_MAX = {FAIL_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_TRY     = 2'd0,
    CMD_SUCCESS = 2'd1,
    CMD_FAIL    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic capture;  // latch the request
    logic lookup;   // search keys, register hit and free slot
    logic update;   // read-modify-write the entry, register the result
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/thcb_ctrl.sv @@
// Controller of the tuple health circuit breaker: sequences capture,
// lookup and update. Depends on thcb_pkg.
`default_nettype none

module thcb_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output thcb_pkg::ctl_t   ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  state_t state;

  assign busy        = (state != ST_IDLE);
  assign ctl.capture = start && !busy;
  assign ctl.lookup  = (state == ST_LOOKUP);
  assign ctl.update  = (state == ST_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) state <= ST_LOOKUP;
        end
        ST_LOOKUP: state <= ST_UPDATE;
        ST_UPDATE: state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/thcb_datapath.sv @@
// Datapath of the tuple health circuit breaker: key table with parallel
// compare, per-entry health records and result registers. Depends on thcb_pkg.
`default_nettype none

module thcb_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire thcb_pkg::ctl_t                   ctl,
  input  wire logic [1:0]                       cmd,
  input  wire logic [thcb_pkg::OP_W-1:0]        operation,
  input  wire logic [thcb_pkg::FMT_W-1:0]       src_format,
  input  wire logic [thcb_pkg::FMT_W-1:0]       dst_format,
  input  wire logic [thcb_pkg::RETRY_W-1:0]     retry_interval,
  input  wire logic [thcb_pkg::THR_W-1:0]       demotion_threshold,
  output logic                                  done,
  output logic                                  allow,
  output logic                                  demoted_now,
  output logic [thcb_pkg::FAIL_W-1:0]           failure_count,
  output logic                                  table_full
);

  // Captured request
  thcb_pkg::cmd_t                   cmd_q;
  logic [thcb_pkg::OP_W-1:0]        op_q;
  logic [thcb_pkg::FMT_W-1:0]       inf_q;
  logic [thcb_pkg::FMT_W-1:0]       outf_q;

  // Table
  logic                             entry_valid     [thcb_pkg::TABLE_ENTRIES];
  logic [thcb_pkg::OP_W-1:0]        entry_operation [thcb_pkg::TABLE_ENTRIES];
  logic [thcb_pkg::FMT_W-1:0]       entry_src_format[thcb_pkg::TABLE_ENTRIES];
  logic [thcb_pkg::FMT_W-1:0]       entry_dst_format[thcb_pkg::TABLE_ENTRIES];
  logic [thcb_pkg::FAIL_W-1:0]      entry_failures  [thcb_pkg::TABLE_ENTRIES];
  logic [thcb_pkg::SKIP_W-1:0]      entry_skipped   [thcb_pkg::TABLE_ENTRIES];
  logic                             entry_demoted   [thcb_pkg::TABLE_ENTRIES];

  // Lookup results
  logic                             hit_c, free_c, hit, free_ok;
  logic [thcb_pkg::IDX_W-1:0]       hit_idx_c, free_idx_c, hit_idx, free_idx;

  // Update
  logic [thcb_pkg::IDX_W-1:0]       sel_idx;
  logic                             ins, wr_en, full_c;
  logic [thcb_pkg::FAIL_W-1:0]      cur_f, f_inc, f_next;
  logic [thcb_pkg::SKIP_W-1:0]      cur_s, s_inc, s_next;
  logic                             cur_d, d_next;
  logic                             allow_c, newly_c;
  logic [thcb_pkg::FAIL_W-1:0]      count_c;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q  <= thcb_pkg::cmd_t'(cmd);
      op_q   <= operation;
      inf_q  <= src_format;
      outf_q <= dst_format;
    end
  end

  // Lowest matching valid entry and lowest free entry; scan from the top so
  // the lowest index is written last.
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = thcb_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_operation[i] == op_q &&
          entry_src_format[i] == inf_q && entry_dst_format[i] == outf_q) begin
        hit_c     = 1'b1;
        hit_idx_c = thcb_pkg::IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_c     = 1'b1;
        free_idx_c = thcb_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      hit      <= hit_c;
      hit_idx  <= hit_idx_c;
      free_ok  <= free_c;
      free_idx <= free_idx_c;
    end
  end

  always_comb begin
    sel_idx = hit ? hit_idx : free_idx;
    ins     = !hit && free_ok && (cmd_q != thcb_pkg::CMD_QUERY);
    full_c  = !hit && !free_ok && (cmd_q != thcb_pkg::CMD_QUERY);
    wr_en   = ctl.update && (hit || ins) && (cmd_q != thcb_pkg::CMD_QUERY);

    // A fresh insert starts from a cleared record
    cur_f = hit ? entry_failures[hit_idx] : '0;
    cur_s = hit ? entry_skipped[hit_idx]  : '0;
    cur_d = hit ? entry_demoted[hit_idx]  : 1'b0;

    f_inc = (cur_f == thcb_pkg::FAIL_MAX) ? cur_f : cur_f + 1'b1;
    s_inc = cur_s + 1'b1;

    f_next  = cur_f;
    s_next  = cur_s;
    d_next  = cur_d;
    allow_c = 1'b0;
    newly_c = 1'b0;
    count_c = '0;

    if (full_c) begin
      allow_c = (cmd_q == thcb_pkg::CMD_TRY);
    end else begin
      unique case (cmd_q)
        thcb_pkg::CMD_TRY: begin
          count_c = cur_f;
          if (cur_d && s_inc <= {1'b0, retry_interval}) begin
            s_next = s_inc;
          end else begin
            s_next  = '0;
            allow_c = 1'b1;
          end
        end
        thcb_pkg::CMD_SUCCESS: begin
          f_next = '0;
          d_next = 1'b0;
        end
        thcb_pkg::CMD_FAIL: begin
          f_next  = f_inc;
          count_c = f_inc;
          if (!cur_d && f_inc >= thcb_pkg::FAIL_W'(demotion_threshold)) begin
            f_next  = thcb_pkg::FAIL_W'(demotion_threshold);
            count_c = thcb_pkg::FAIL_W'(demotion_threshold);
            d_next  = 1'b1;
            s_next  = '0;
            newly_c = 1'b1;
          end
        end
        thcb_pkg::CMD_QUERY: begin
          count_c = cur_f;
        end
        default: begin
          count_c = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < thcb_pkg::TABLE_ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (wr_en && ins) begin
      entry_valid[sel_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_failures[sel_idx] <= f_next;
      entry_skipped[sel_idx]  <= s_next;
      entry_demoted[sel_idx]  <= d_next;
      if (ins) begin
        entry_operation[sel_idx]  <= op_q;
        entry_src_format[sel_idx] <= inf_q;
        entry_dst_format[sel_idx] <= outf_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.update;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      allow         <= allow_c;
      demoted_now   <= newly_c;
      failure_count <= count_c;
      table_full    <= full_c;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tuple_health_circuit_breaker.sv @@
// Top level of the tuple health circuit breaker: configuration registers,
// controller and datapath. Depends on thcb_pkg, thcb_ctrl, thcb_datapath.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+-------------------------------------
//   request   | start, busy               | cmd, operation, src_format, dst_format
//   result    | done (one-cycle strobe)   | allow, demoted_now, failure_count,
//             |                           | table_full
//   config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// A request taken at an edge is captured, then passes the parallel key compare
// (lookup) and the entry read-modify-write (update); done then shows the result
// with the result registers on the ports. busy is high during lookup and update,
// so a new request can be taken in the cycle the previous result is shown.
// Synchronous reset clears the table's valid bits and restores the register
// defaults. The result side cannot stall; config writes are always taken.
`default_nettype none

module tuple_health_circuit_breaker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         cmd,
  input  wire logic [thcb_pkg::OP_W-1:0]          operation,
  input  wire logic [thcb_pkg::FMT_W-1:0]         src_format,
  input  wire logic [thcb_pkg::FMT_W-1:0]         dst_format,
  output logic                                    done,
  output logic                                    allow,
  output logic                                    demoted_now,
  output logic [thcb_pkg::FAIL_W-1:0]             failure_count,
  output logic                                    table_full,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [thcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [thcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  thcb_pkg::ctl_t                     ctl;
  logic [thcb_pkg::RETRY_W-1:0]       retry_interval;
  logic [thcb_pkg::THR_W-1:0]         demotion_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval     <= thcb_pkg::RETRY_RESET;
      demotion_threshold <= thcb_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        thcb_pkg::CFG_RETRY_INTERVAL: retry_interval <= cfg_data;
        thcb_pkg::CFG_DEMOTE_THRESH:
          demotion_threshold <= cfg_data[thcb_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  thcb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  thcb_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .cmd                (cmd),
    .operation          (operation),
    .src_format         (src_format),
    .dst_format         (dst_format),
    .retry_interval     (retry_interval),
    .demotion_threshold (demotion_threshold),
    .done               (done),
    .allow              (allow),
    .demoted_now        (demoted_now),
    .failure_count      (failure_count),
    .table_full         (table_full)
  );

endmodule

`default_nettype wire

@@ hw/rtl/thcb_checker.sv @@
// Port-level checker for the tuple health circuit breaker, bound to the top.
// Depends on tuple_health_circuit_breaker_defines.svh.
`default_nettype none
`include "tuple_health_circuit_breaker_defines.svh"

module thcb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic allow,
  input wire logic demoted_now,
  input wire logic table_full
);

  `THCB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `THCB_ASSERT_IMP(a_done_latency, start && !busy, ##3 done, "result not shown three cycles after transfer")
  `THCB_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
  `THCB_ASSERT_IMP(a_demote_excl, done && demoted_now, !allow && !table_full, "demoted_now with conflicting flags")

endmodule

bind tuple_health_circuit_breaker thcb_checker u_thcb_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .allow         (allow),
  .demoted_now   (demoted_now),
  .table_full    (table_full)
);

`default_nettype wire

@@ tb/sv/thcb_health_checker.sv @@
// Checker for the tuple health circuit breaker: tracks register writes, predicts
// each request's result with its own copy of the health table, compares results.
// Depends on thcb_pkg.
module thcb_health_checker
  import thcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            cmd,
  input  logic [OP_W-1:0]       operation,
  input  logic [FMT_W-1:0]      src_format,
  input  logic [FMT_W-1:0]      dst_format,
  input  logic                  done,
  input  logic                  allow,
  input  logic                  demoted_now,
  input  logic [FAIL_W-1:0]     failure_count,
  input  logic                  table_full,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending_results,
  output int                    results_checked,
  output int                    demotions_seen,
  output int                    full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TUPLE_W = OP_W + 2 * FMT_W;

  typedef struct packed {
    logic              allow;
    logic              demoted_now;
    logic [FAIL_W-1:0] failure_count;
    logic              table_full;
  } verdict_t;

  logic [RETRY_W-1:0] retry_limit;
  logic [THR_W-1:0]   demote_at;

  logic               slot_used    [TABLE_ENTRIES];
  logic [TUPLE_W-1:0] slot_tuple   [TABLE_ENTRIES];
  logic [FAIL_W-1:0]  slot_failures[TABLE_ENTRIES];
  logic [SKIP_W-1:0]  slot_skips   [TABLE_ENTRIES];
  logic               slot_demoted [TABLE_ENTRIES];

  verdict_t verdicts_due[$];

  function automatic verdict_t advance_health(input cmd_t req, input logic [TUPLE_W-1:0] tuple);
    verdict_t          v;
    int                hit;
    int                spare;
    logic [SKIP_W-1:0] skips;
    logic [FAIL_W:0]   fails;
    v = '0;
    hit = -1;
    spare = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_tuple[i] == tuple) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (req == CMD_QUERY) begin
      if (hit >= 0) v.failure_count = slot_failures[hit];
      return v;
    end
    if (hit < 0 && spare >= 0) begin
      hit = spare;
      slot_used[hit]     = 1'b1;
      slot_tuple[hit]    = tuple;
      slot_failures[hit] = '0;
      slot_skips[hit]    = '0;
      slot_demoted[hit]  = 1'b0;
    end
    // no room for a new tuple: let it through untracked
    if (hit < 0) begin
      v.table_full = 1'b1;
      v.allow = (req == CMD_TRY);
      return v;
    end
    case (req)
      CMD_TRY: begin
        if (slot_demoted[hit]) begin
          skips = slot_skips[hit] + 1'b1;
          if (skips <= {1'b0, retry_limit}) begin
            slot_skips[hit] = skips;
          end else begin
            slot_skips[hit] = '0;
            v.allow = 1'b1;
          end
        end else begin
          slot_skips[hit] = '0;
          v.allow = 1'b1;
        end
        v.failure_count = slot_failures[hit];
      end
      CMD_SUCCESS: begin
        slot_failures[hit] = '0;
        slot_demoted[hit]  = 1'b0;
      end
      default: begin
        fails = {1'b0, slot_failures[hit]};
        if (fails < FAIL_MAX) fails = fails + 1'b1;
        // clamp to the threshold on the demoting failure
        if (!slot_demoted[hit] && fails >= demote_at) begin
          fails = {{(FAIL_W + 1 - THR_W){1'b0}}, demote_at};
          slot_demoted[hit] = 1'b1;
          slot_skips[hit]   = '0;
          v.demoted_now     = 1'b1;
        end
        slot_failures[hit] = fails[FAIL_W-1:0];
        v.failure_count    = fails[FAIL_W-1:0];
      end
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : observe
    verdict_t want;
    if (rst) begin
      retry_limit = RETRY_RESET;
      demote_at   = THRESH_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      verdicts_due.delete();
      mismatches      = 0;
      results_checked = 0;
      demotions_seen  = 0;
      full_seen       = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RETRY_INTERVAL: retry_limit = cfg_data[RETRY_W-1:0];
          CFG_DEMOTE_THRESH:  demote_at   = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      // retire the oldest expectation before queuing a new request
      if (done) begin
        if (verdicts_due.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("allow", 32'(want.allow), 32'(allow));
          check_field("demoted_now", 32'(want.demoted_now), 32'(demoted_now));
          check_field("failure_count", 32'(want.failure_count), 32'(failure_count));
          check_field("table_full", 32'(want.table_full), 32'(table_full));
          results_checked++;
          demotions_seen += int'(want.demoted_now);
          full_seen      += int'(want.table_full);
        end
      end
      if (start && !busy)
        verdicts_due.push_back(advance_health(cmd_t'(cmd), {operation, src_format, dst_format}));
    end
    pending_results = verdicts_due.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the tuple health circuit breaker: clock, reset, request and
// register stimulus, watchdog and verdict. Depends on thcb_pkg, the block and
// thcb_health_checker.
module tb_top;
  import thcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [FMT_W-1:0] src;
    logic [FMT_W-1:0] dst;
  } tuple_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  cmd_t                  cmd = CMD_TRY;
  logic [OP_W-1:0]       operation = '0;
  logic [FMT_W-1:0]      src_format = '0;
  logic [FMT_W-1:0]      dst_format = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RETRY_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  done;
  logic                  allow;
  logic                  demoted_now;
  logic [FAIL_W-1:0]     failure_count;
  logic                  table_full;
  logic                  cfg_ready;

  int mismatches;
  int pending_results;
  int results_checked;
  int demotions_seen;
  int full_seen;

  int     items_sent = 0;
  int     settings_used = 1;
  int     idle_cycles = 0;
  bit     steady = 1'b0;
  tuple_t pool[TABLE_ENTRIES];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tuple_health_circuit_breaker u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .operation(operation), .src_format(src_format), .dst_format(dst_format),
    .done(done), .allow(allow), .demoted_now(demoted_now),
    .failure_count(failure_count), .table_full(table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  thcb_health_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .operation(operation), .src_format(src_format), .dst_format(dst_format),
    .done(done), .allow(allow), .demoted_now(demoted_now),
    .failure_count(failure_count), .table_full(table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .pending_results(pending_results),
    .results_checked(results_checked), .demotions_seen(demotions_seen),
    .full_seen(full_seen)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic tuple_t any_tuple();
    tuple_t k;
    k.op  = OP_W'($urandom);
    k.src = FMT_W'($urandom);
    k.dst = FMT_W'($urandom);
    return k;
  endfunction

  function automatic bit in_pool(input tuple_t k, input int upto);
    for (int i = 0; i < upto; i++)
      if (pool[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic tuple_t fresh_tuple();
    tuple_t k;
    do k = any_tuple(); while (in_pool(k, TABLE_ENTRIES));
    return k;
  endfunction

  // mostly the tracked tuples, now and then one that cannot be inserted
  function automatic tuple_t pick_tuple();
    if ($urandom_range(0, 99) < 88) return pool[$urandom_range(0, TABLE_ENTRIES - 1)];
    return any_tuple();
  endfunction

  function automatic cmd_t pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_TRY;
    if (r < 70) return CMD_FAIL;
    if (r < 82) return CMD_SUCCESS;
    return CMD_QUERY;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start is left high when the next request follows at once
  task automatic issue(input cmd_t c, input tuple_t k);
    int gap;
    start      <= 1'b1;
    cmd        <= c;
    operation  <= k.op;
    src_format <= k.src;
    dst_format <= k.dst;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic program_breaker(input logic [CFG_DATA_W-1:0] retry,
                                 input logic [CFG_DATA_W-1:0] thresh);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RETRY_INTERVAL;
    cfg_data  <= retry;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_DEMOTE_THRESH;
    cfg_data  <= thresh;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 4) == 0);
      issue(pick_cmd(), pick_tuple());
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    cmd_t   fill_cmds[3];
    tuple_t outsider;
    fill_cmds = '{CMD_TRY, CMD_SUCCESS, CMD_FAIL};
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < TABLE_ENTRIES; i++)
      do pool[i] = any_tuple(); while (in_pool(pool[i], i));

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: absent query, insert, demotion, refusal, recovery
    issue(CMD_QUERY, pool[0]);
    issue(CMD_TRY, pool[0]);
    repeat (3) issue(CMD_FAIL, pool[0]);
    issue(CMD_TRY, pool[0]);
    issue(CMD_SUCCESS, pool[0]);
    // fill the table with the rest of the pool
    for (int i = 1; i < TABLE_ENTRIES; i++) issue(fill_cmds[i % 3], pool[i]);
    outsider = fresh_tuple();
    issue(CMD_TRY, outsider);
    issue(CMD_SUCCESS, outsider);
    issue(CMD_FAIL, outsider);
    issue(CMD_QUERY, outsider);
    run_random(350);

    program_breaker(16'd0, 16'd1);
    run_random(300);

    // keep demoted tuples refused so their skip counts climb
    program_breaker(16'hFFFF, 16'd2);
    run_random(300);

    // lowered interval releases long-skipped tuples; zero threshold
    program_breaker(16'd4, 16'd0);
    run_random(250);

    // drive one tuple to the top threshold and keep counting past it
    program_breaker(16'd7, 16'h5AFF);
    steady = 1'b1;
    issue(CMD_SUCCESS, pool[2]);
    repeat (260) issue(CMD_FAIL, pool[2]);
    repeat (9) issue(CMD_TRY, pool[2]);
    issue(CMD_QUERY, pool[2]);
    steady = 1'b0;

    program_breaker(CFG_DATA_W'($urandom_range(0, 40)),
                    {8'($urandom), 8'($urandom_range(1, 6))});
    run_random(250);

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d requests over %0d register settings, %0d results checked",
             items_sent, settings_used, results_checked);
    $display("saw %0d demotions and %0d table-full results", demotions_seen, full_seen);
    if (mismatches == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
